### rtl/tts_pkg.sv
// Shared types and constants for the top-K threshold select core.
// Used by tts_front, tts_queue, tts_back and topk_threshold_select_core.
package tts_pkg;

   localparam int COUNT_W          = 32;
   localparam int HEAVY_W          = 13;
   localparam int HEAVY_FIELD_MAX  = 8191;
   localparam int NUM_ANOMS_W      = 5;
   localparam int CSR_INDEX_W      = 1;
   localparam int CSR_DATA_W       = 32;

   localparam int MAX_ANOMS_DEF    = 16;
   localparam int ROW_COUNTERS_DEF = 4096;
   localparam int QUEUE_DEPTH      = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_THRESHOLD = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_ANOMS     = 1'b1;

   typedef enum logic [1:0] {
      STATUS_NONE = 2'd0,
      STATUS_MIN  = 2'd1,
      STATUS_KTH  = 2'd2
   } status_type;

   // One classified counter as it travels from front to back.
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               heavy;
      logic               last;
      logic [HEAVY_W-1:0] heavy_total;
   } entry_type;

endpackage

### rtl/tts_front.sv
// Front end: classifies each counter against the minimum and keeps the
// saturating heavy count of the row. Depends on tts_pkg.
module tts_front #(
   parameter int ROW_COUNTERS = tts_pkg::ROW_COUNTERS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [tts_pkg::COUNT_W-1:0]  req_count,
   input  logic                         req_last,
   input  logic [tts_pkg::COUNT_W-1:0]  min_threshold,
   input  logic                         queue_full,
   output logic                         req_stall,
   output logic                         push,
   output tts_pkg::entry_type           push_entry
);

   localparam int HEAVY_CAP_I = (ROW_COUNTERS < tts_pkg::HEAVY_FIELD_MAX) ?
                                ROW_COUNTERS : tts_pkg::HEAVY_FIELD_MAX;
   localparam logic [tts_pkg::HEAVY_W-1:0] HEAVY_CAP = tts_pkg::HEAVY_W'(HEAVY_CAP_I);

   logic [tts_pkg::HEAVY_W-1:0] heavy_seen_ff;
   logic [tts_pkg::HEAVY_W-1:0] heavy_seen_in;
   logic                        heavy;
   logic [tts_pkg::HEAVY_W-1:0] heavy_total;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign heavy     = req_count > min_threshold;

   always_comb begin
      if (heavy && (heavy_seen_ff < HEAVY_CAP)) begin
         heavy_total = heavy_seen_ff + 1'b1;
      end else begin
         heavy_total = heavy_seen_ff;
      end
   end

   always_comb begin
      push_entry.count       = req_count;
      push_entry.heavy       = heavy;
      push_entry.last        = req_last;
      push_entry.heavy_total = heavy_total;
   end

   // Restart the tally after the last counter of a row.
   always_comb begin
      heavy_seen_in = heavy_seen_ff;
      if (push) begin
         heavy_seen_in = req_last ? '0 : heavy_total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heavy_seen_ff <= '0;
      end else begin
         heavy_seen_ff <= heavy_seen_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) heavy_seen_ff <= HEAVY_CAP)
      else $error("heavy tally above its cap");
   assert property (@(posedge clock) disable iff (reset) push && req_last |=> heavy_seen_ff == '0)
      else $error("heavy tally not cleared after last counter");

endmodule

### rtl/tts_queue.sv
// Short queue between front and back so each side can stall on its own.
// Depends on tts_pkg.
module tts_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tts_pkg::entry_type push_entry,
   input  logic               pop,
   output logic               full,
   output logic               head_valid,
   output tts_pkg::entry_type head_entry
);

   localparam int DEPTH = tts_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

   tts_pkg::entry_type slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   assign full       = fill_ff == DEPTH_C;
   assign head_valid = fill_ff != '0;
   assign head_entry = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_P) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_P) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assert property (@(posedge clock) disable iff (reset) fill_ff <= DEPTH_C)
      else $error("queue fill above depth");
   assert property (@(posedge clock) disable iff (reset) !(pop && fill_ff == '0))
      else $error("pop from empty queue");

endmodule

### rtl/tts_back.sv
// Back end: sorted top-K register chain, result selection and the result
// register. Depends on tts_pkg.
module tts_back #(
   parameter int MAX_ANOMS = tts_pkg::MAX_ANOMS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   input  tts_pkg::entry_type               head_entry,
   input  logic [tts_pkg::COUNT_W-1:0]      min_threshold,
   input  logic [tts_pkg::NUM_ANOMS_W-1:0]  num_anoms,
   output logic                             pop,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [tts_pkg::COUNT_W-1:0]      rsp_threshold,
   output logic [1:0]                       rsp_status,
   output logic [tts_pkg::HEAVY_W-1:0]      rsp_heavy_total
);

   localparam int IDX_W = (MAX_ANOMS > 1) ? $clog2(MAX_ANOMS) : 1;

   logic [tts_pkg::COUNT_W-1:0] top_counts_ff [MAX_ANOMS];
   logic [tts_pkg::COUNT_W-1:0] ins_counts    [MAX_ANOMS];
   logic [tts_pkg::COUNT_W-1:0] sel_counts    [MAX_ANOMS];
   logic [MAX_ANOMS-1:0] top_valid_ff, top_valid_in;
   logic [MAX_ANOMS-1:0] ins_valid, sel_valid;
   logic [MAX_ANOMS-1:0] ins_here, ins_prev;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tts_pkg::COUNT_W-1:0] rsp_threshold_ff;
   tts_pkg::status_type         rsp_status_ff;
   logic [tts_pkg::HEAVY_W-1:0] rsp_heavy_total_ff;

   logic [31:0]                 k_eff;
   logic [IDX_W-1:0]            k_idx;
   logic [tts_pkg::COUNT_W-1:0] thr_next;
   tts_pkg::status_type         status_next;
   logic                        finish;

   // Hold a last item while an earlier result still waits.
   assign pop    = head_valid && (!head_entry.last || !rsp_valid_ff || !rsp_stall);
   assign finish = pop && head_entry.last;

   // Valid entries form a prefix sorted high to low, so the insert flags
   // form a thermometer and the first set flag marks the slot.
   always_comb begin
      for (int i = 0; i < MAX_ANOMS; i++) begin
         ins_here[i] = !top_valid_ff[i] || (top_counts_ff[i] < head_entry.count);
      end
      ins_prev = ins_here << 1;
   end

   for (genvar g = 0; g < MAX_ANOMS; g++) begin : g_slot
      if (g == 0) begin : g_head
         assign ins_counts[g] = ins_here[g] ? head_entry.count : top_counts_ff[g];
         assign ins_valid[g]  = ins_here[g] | top_valid_ff[g];
      end else begin : g_rest
         always_comb begin
            if (!ins_here[g]) begin
               ins_counts[g] = top_counts_ff[g];
               ins_valid[g]  = top_valid_ff[g];
            end else if (ins_prev[g]) begin
               ins_counts[g] = top_counts_ff[g-1];
               ins_valid[g]  = top_valid_ff[g-1];
            end else begin
               ins_counts[g] = head_entry.count;
               ins_valid[g]  = 1'b1;
            end
         end
      end
      assign sel_counts[g] = head_entry.heavy ? ins_counts[g] : top_counts_ff[g];
      assign sel_valid[g]  = head_entry.heavy ? ins_valid[g]  : top_valid_ff[g];
   end

   // Clip K into 1..MAX_ANOMS.
   always_comb begin
      k_eff = {{(32 - tts_pkg::NUM_ANOMS_W){1'b0}}, num_anoms};
      if (k_eff == 32'd0) begin
         k_eff = 32'd1;
      end else if (k_eff > 32'(MAX_ANOMS)) begin
         k_eff = 32'(MAX_ANOMS);
      end
      k_idx = IDX_W'(k_eff - 32'd1);
   end

   always_comb begin
      if (head_entry.heavy_total == '0) begin
         status_next = tts_pkg::STATUS_NONE;
         thr_next    = '0;
      end else if ({{(32 - tts_pkg::HEAVY_W){1'b0}}, head_entry.heavy_total} <= k_eff) begin
         status_next = tts_pkg::STATUS_MIN;
         thr_next    = min_threshold;
      end else begin
         status_next = tts_pkg::STATUS_KTH;
         thr_next    = sel_valid[k_idx] ? sel_counts[k_idx] : '0;
      end
   end

   always_comb begin
      top_valid_in = top_valid_ff;
      if (finish) begin
         top_valid_in = '0;
      end else if (pop && head_entry.heavy) begin
         top_valid_in = ins_valid;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         top_valid_ff <= top_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head_entry.heavy) begin
         for (int i = 0; i < MAX_ANOMS; i++) begin
            top_counts_ff[i] <= ins_counts[i];
         end
      end
      if (finish) begin
         rsp_threshold_ff   <= thr_next;
         rsp_status_ff      <= status_next;
         rsp_heavy_total_ff <= head_entry.heavy_total;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_threshold   = rsp_threshold_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_heavy_total = rsp_heavy_total_ff;

   assert property (@(posedge clock) disable iff (reset)
                    ((top_valid_ff >> 1) & ~top_valid_ff) == '0)
      else $error("chain valid bits not a prefix");
   assert property (@(posedge clock) disable iff (reset) finish |=> top_valid_ff == '0)
      else $error("chain not cleared after row end");
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid_ff && rsp_stall |-> !finish)
      else $error("result overwritten while stalled");

endmodule

### rtl/topk_threshold_select_core.sv
// Top level of the top-K threshold select core: configuration registers,
// front classifier, queue and top-K back end. Depends on tts_pkg and submodules.
//
//   channel | ports                                        | direction
//   req     | req_valid req_stall req_count req_last       | in (stall out)
//   rsp     | rsp_valid rsp_stall rsp_threshold rsp_status  | out (stall in)
//           | rsp_heavy_total                              |
//   csr     | csr_write csr_index csr_wdata                | in, write only
//
// One counter per cycle while req_stall is low; the top-K chain inserts as it pops.
// With the queue empty, a row's last counter passes a queue slot and then the
// result register before its result is valid, unless an earlier result waits.
// The 4-entry queue lets the front keep taking counters while a result waits.
// Synchronous reset clears control and chain valid bits, zeroes the minimum and sets K to 1.
module topk_threshold_select_core #(
   parameter int MAX_ANOMS    = tts_pkg::MAX_ANOMS_DEF,
   parameter int ROW_COUNTERS = tts_pkg::ROW_COUNTERS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [tts_pkg::COUNT_W-1:0]     req_count,
   input  logic                            req_last,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tts_pkg::COUNT_W-1:0]     rsp_threshold,
   output logic [1:0]                      rsp_status,
   output logic [tts_pkg::HEAVY_W-1:0]     rsp_heavy_total,
   input  logic                            csr_write,
   input  logic [tts_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tts_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic [tts_pkg::COUNT_W-1:0]     min_threshold_ff, min_threshold_in;
   logic [tts_pkg::NUM_ANOMS_W-1:0] num_anoms_ff, num_anoms_in;

   logic               push, pop, queue_full, head_valid;
   tts_pkg::entry_type push_entry, head_entry;

   always_comb begin
      min_threshold_in = min_threshold_ff;
      num_anoms_in     = num_anoms_ff;
      if (csr_write) begin
         unique case (csr_index)
            tts_pkg::CSR_MIN_THRESHOLD: min_threshold_in = csr_wdata;
            tts_pkg::CSR_NUM_ANOMS:     num_anoms_in = csr_wdata[tts_pkg::NUM_ANOMS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_threshold_ff <= '0;
         num_anoms_ff     <= tts_pkg::NUM_ANOMS_W'(1);
      end else begin
         min_threshold_ff <= min_threshold_in;
         num_anoms_ff     <= num_anoms_in;
      end
   end

   tts_front #(
      .ROW_COUNTERS (ROW_COUNTERS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_count     (req_count),
      .req_last      (req_last),
      .min_threshold (min_threshold_ff),
      .queue_full    (queue_full),
      .req_stall     (req_stall),
      .push          (push),
      .push_entry    (push_entry)
   );

   tts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   tts_back #(
      .MAX_ANOMS (MAX_ANOMS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_entry      (head_entry),
      .min_threshold   (min_threshold_ff),
      .num_anoms       (num_anoms_ff),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_threshold   (rsp_threshold),
      .rsp_status      (rsp_status),
      .rsp_heavy_total (rsp_heavy_total)
   );

endmodule
